// ----- hw/rtl/awb_pkg.sv -----
// ----------------------------------------------------------------------------
// awb_pkg: shared types and constants of the affine warp block
// Register indexes, input mode codes, the configuration struct and the item
// struct of the command queue that joins the front and back parts.
// ----------------------------------------------------------------------------
package awb_pkg;

  localparam int unsigned DestMax = 1024;
  localparam int unsigned CoordW  = $clog2(DestMax);
  localparam int unsigned PixW    = 8;
  localparam int unsigned CoefW   = 32;
  localparam int unsigned SizeW   = 9;

  // register indexes
  localparam logic [2:0] RegCoefXx  = 3'd0;
  localparam logic [2:0] RegCoefXy  = 3'd1;
  localparam logic [2:0] RegCoefYx  = 3'd2;
  localparam logic [2:0] RegCoefYy  = 3'd3;
  localparam logic [2:0] RegOffsetX = 3'd4;
  localparam logic [2:0] RegOffsetY = 3'd5;
  localparam logic [2:0] RegSrcW    = 3'd6;
  localparam logic [2:0] RegSrcH    = 3'd7;

  typedef enum logic {
    ModeWrite   = 1'b0,
    ModeRequest = 1'b1
  } mode_e;

  // configuration registers seen by the back part
  typedef struct packed {
    logic signed [CoefW-1:0] coef_xx;
    logic signed [CoefW-1:0] coef_xy;
    logic signed [CoefW-1:0] coef_yx;
    logic signed [CoefW-1:0] coef_yy;
    logic signed [CoefW-1:0] offset_x;
    logic signed [CoefW-1:0] offset_y;
    logic [SizeW-1:0]        src_width;
    logic [SizeW-1:0]        src_height;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    mode_e             mode;
    logic              keep;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [PixW-1:0]   pix;
  } cmd_t;

endpackage

// ----- hw/rtl/awb_if.sv -----
// ----------------------------------------------------------------------------
// awb_in_if / awb_out_if: valid-ready channels of the affine warp block
// Input carries one write or request beat, output carries one result beat.
// ----------------------------------------------------------------------------
interface awb_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [awb_pkg::CoordW-1:0] coord_x;
  logic [awb_pkg::CoordW-1:0] coord_y;
  logic [awb_pkg::PixW-1:0]   pixel_in;
  modport source (output valid, mode, coord_x, coord_y, pixel_in, input ready);
  modport sink   (input valid, mode, coord_x, coord_y, pixel_in, output ready);
endinterface

interface awb_out_if;
  logic                     valid;
  logic                     ready;
  logic [awb_pkg::PixW-1:0] pixel_out;
  logic                     in_bounds;
  modport source (output valid, pixel_out, in_bounds, input ready);
  modport sink   (input valid, pixel_out, in_bounds, output ready);
endinterface

// ----- hw/rtl/awb_front.sv -----
// ----------------------------------------------------------------------------
// awb_front: accept and classify input beats
// Marks writes outside the store as dropped and pushes each item into a
// short queue toward the back part.
// ----------------------------------------------------------------------------
module awb_front #(
  parameter int unsigned SRC_MAX_W = 256,
  parameter int unsigned SRC_MAX_H = 256,
  parameter int unsigned DEPTH     = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  awb_in_if.sink        in_if,
  output logic          cmd_valid_o,
  output awb_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  awb_pkg::cmd_t      fifo_q [DEPTH];
  logic [PtrW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]      cnt_q, cnt_d;
  logic               push;
  awb_pkg::cmd_t      cmd_new;

  assign in_if.ready = (cnt_q < (PtrW+1)'(DEPTH));
  assign push        = in_if.valid && in_if.ready;

  // classify
  always_comb begin
    cmd_new.mode = awb_pkg::mode_e'(in_if.mode);
    cmd_new.keep = (32'(in_if.coord_x) < SRC_MAX_W) && (32'(in_if.coord_y) < SRC_MAX_H);
    cmd_new.x    = in_if.coord_x;
    cmd_new.y    = in_if.coord_y;
    cmd_new.pix  = in_if.pixel_in;
  end

  // queue pointers
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d  = (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + PtrW'(1);
    end
    if (cmd_pop_i) begin
      rd_d  = (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + PtrW'(1);
    end
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= cmd_new;
    end
  end

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_q];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= DEPTH) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o) else $error("pop from empty queue");
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cnt_q) == DEPTH) |-> !in_if.ready) else $error("ready while full");
`endif
endmodule

// ----- hw/rtl/awb_back.sv -----
// ----------------------------------------------------------------------------
// awb_back: carry out writes and warp requests
// Sequencer: map and floor, read four store neighbours in turn unless outside,
// blend with two multiply stages, hold result in an output register.
// ----------------------------------------------------------------------------
module awb_back #(
  parameter int unsigned SRC_MAX_W = 256,
  parameter int unsigned SRC_MAX_H = 256,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  awb_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  awb_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  awb_out_if.source     out_if
);
  localparam int unsigned XW    = (SRC_MAX_W > 1) ? $clog2(SRC_MAX_W) : 1;
  localparam int unsigned YW    = (SRC_MAX_H > 1) ? $clog2(SRC_MAX_H) : 1;
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned PW    = 64;
  localparam int unsigned FW    = FRAC_BITS + 1;
  localparam int unsigned SW    = 2 * FW + 8 + 2;

  // sequencer states
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StMx0  = 4'd1;
  localparam logic [3:0] StMx1  = 4'd2;
  localparam logic [3:0] StSum  = 4'd3;
  localparam logic [3:0] StRd0  = 4'd4;
  localparam logic [3:0] StRd1  = 4'd5;
  localparam logic [3:0] StRd2  = 4'd6;
  localparam logic [3:0] StRd3  = 4'd7;
  localparam logic [3:0] StAcc  = 4'd8;
  localparam logic [3:0] StFin  = 4'd9;

  logic [awb_pkg::PixW-1:0] mem_q [DEPTH];
  logic [awb_pkg::PixW-1:0] rdata_q;

  logic [3:0]          st_q, st_d;
  logic [awb_pkg::CoordW-1:0] x_q, y_q;
  logic signed [PW-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [PW-1:0] sx_q, sy_q;
  logic [FW-1:0]       fx_q, fy_q, mx_q, my_q;
  logic [AW-1:0]       base_q;
  logic [1:0]          tap_q;
  logic [2*FW-1:0]     wgt_q;
  logic [SW-1:0]       acc_q;
  logic [awb_pkg::PixW-1:0] rpix_q;
  logic                rinb_q;
  logic                ovalid_q;
  logic [awb_pkg::PixW-1:0] opix_q;
  logic                oinb_q;

  logic signed [PW-1:0] ix, iy;
  logic [31:0]          wsat, hsat;
  logic                 nb_in;
  logic                 fin_go;
  logic [AW-1:0]        raddr;
  logic [FW-1:0]        wa, wb;
  logic [SW-1:0]        rnd;

  // saturate source size to the store
  assign wsat = (32'(cfg_i.src_width)  > SRC_MAX_W) ? SRC_MAX_W : 32'(cfg_i.src_width);
  assign hsat = (32'(cfg_i.src_height) > SRC_MAX_H) ? SRC_MAX_H : 32'(cfg_i.src_height);

  // arithmetic shift is the floor; size below two leaves no room
  assign ix = sx_q >>> FRAC_BITS;
  assign iy = sy_q >>> FRAC_BITS;
  assign nb_in = (ix >= 0) && (iy >= 0) && (ix < $signed(PW'(wsat) - PW'(1)))
                 && (iy < $signed(PW'(hsat) - PW'(1)));

  // neighbour address for the current tap
  always_comb begin
    unique case (tap_q)
      2'd0:    raddr = base_q;
      2'd1:    raddr = base_q + AW'(1);
      2'd2:    raddr = base_q + (AW'(1) << XW);
      default: raddr = base_q + (AW'(1) << XW) + AW'(1);
    endcase
    unique case (tap_q)
      2'd0:    begin wa = mx_q; wb = my_q; end
      2'd1:    begin wa = fx_q; wb = my_q; end
      2'd2:    begin wa = mx_q; wb = fy_q; end
      default: begin wa = fx_q; wb = fy_q; end
    endcase
  end

  assign cmd_pop_o = (st_q == StIdle) && cmd_valid_i;
  assign fin_go    = (st_q == StFin) && (!ovalid_q || out_if.ready);
  assign rnd       = acc_q + (SW'(1) << (2 * FRAC_BITS - 1));

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (cmd_pop_o && cmd_i.mode == awb_pkg::ModeRequest) st_d = StMx0;
      StMx0:  st_d = StMx1;
      StMx1:  st_d = StSum;
      StSum:  st_d = StRd0;
      StRd0:  st_d = nb_in ? StRd1 : StFin;
      StRd1:  st_d = StRd2;
      StRd2:  st_d = (tap_q == 2'd3) ? StAcc : StRd3;
      StRd3:  st_d = StRd2;
      StAcc:  st_d = StFin;
      StFin:  st_d = fin_go ? StIdle : StFin;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;
      if (fin_go) ovalid_q <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        x_q <= cmd_i.x;
        y_q <= cmd_i.y;
      end
      StMx0: begin
        pa_q <= PW'(cfg_i.coef_xx) * PW'($signed({1'b0, x_q}));
        pb_q <= PW'(cfg_i.coef_xy) * PW'($signed({1'b0, y_q}));
      end
      StMx1: begin
        sx_q <= pa_q + pb_q + PW'(cfg_i.offset_x);
        pc_q <= PW'(cfg_i.coef_yx) * PW'($signed({1'b0, x_q}));
        pd_q <= PW'(cfg_i.coef_yy) * PW'($signed({1'b0, y_q}));
      end
      StSum: begin
        sy_q <= pc_q + pd_q + PW'(cfg_i.offset_y);
      end
      StRd0: begin
        fx_q   <= {1'b0, sx_q[FRAC_BITS-1:0]};
        fy_q   <= {1'b0, sy_q[FRAC_BITS-1:0]};
        mx_q   <= (FW'(1) << FRAC_BITS) - {1'b0, sx_q[FRAC_BITS-1:0]};
        my_q   <= (FW'(1) << FRAC_BITS) - {1'b0, sy_q[FRAC_BITS-1:0]};
        base_q <= {iy[YW-1:0], ix[XW-1:0]};
        tap_q  <= 2'd0;
        acc_q  <= '0;
        rpix_q <= '0;
        rinb_q <= 1'b0;
      end
      StRd1: begin
        wgt_q <= wa * wb;
      end
      StRd2: begin
        acc_q <= acc_q + SW'(wgt_q) * SW'(rdata_q);
        tap_q <= tap_q + 2'd1;
      end
      StRd3: begin
        wgt_q <= wa * wb;
      end
      StAcc: begin
        rpix_q <= (rnd >> (2 * FRAC_BITS) > SW'(255)) ? 8'hFF
                  : rnd[2*FRAC_BITS +: awb_pkg::PixW];
        rinb_q <= 1'b1;
      end
      StFin: begin
        // hand the result to the output register once it is free
        if (fin_go) begin
          opix_q <= rpix_q;
          oinb_q <= rinb_q;
        end
      end
      default: ;
    endcase
  end

  // store: at most one write and one read per cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.mode == awb_pkg::ModeWrite && cmd_i.keep) begin
      mem_q[{cmd_i.y[YW-1:0], cmd_i.x[XW-1:0]}] <= cmd_i.pix;
    end
    rdata_q <= mem_q[raddr];
  end

  assign out_if.valid     = ovalid_q;
  assign out_if.pixel_out = opix_q;
  assign out_if.in_bounds = oinb_q;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (st_q == StIdle)) else $error("pop while busy");
  a_fin_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> ovalid_q) else $error("result lost");
  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !oinb_q) |-> (opix_q == '0)) else $error("outside result nonzero");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_if.ready) |=> ovalid_q && $stable(opix_q) && $stable(oinb_q))
    else $error("result changed while waiting");
`endif
endmodule

// ----- hw/rtl/affine_warp_bilinear.sv -----
// ----------------------------------------------------------------------------
// affine_warp_bilinear: inverse affine warp with bilinear sampling
// A write goes through the command queue into the store; the sequencer maps a
// request, reads four store neighbours unless outside, and blends them. Writes
// pass one per cycle while the back part is idle, which takes no new item until
// a request's result is in the output register; a waiting result stalls writes.
// Reset clears control and sets the configuration registers to their reset
// values; the source store holds no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
module affine_warp_bilinear #(
  parameter int unsigned SRC_MAX_W = 256,
  parameter int unsigned SRC_MAX_H = 256,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  awb_in_if.sink      in_if,
  awb_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  awb_pkg::cfg_t cfg_q;
  awb_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_pop;
  logic [2:0]    ridx;

  assign ridx   = paddr[4:2];
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_xx    <= 32'sd65536;
      cfg_q.coef_xy    <= '0;
      cfg_q.coef_yx    <= '0;
      cfg_q.coef_yy    <= 32'sd65536;
      cfg_q.offset_x   <= '0;
      cfg_q.offset_y   <= '0;
      cfg_q.src_width  <= 9'd256;
      cfg_q.src_height <= 9'd256;
    end else if (psel && penable && pwrite && pready) begin
      unique case (ridx)
        awb_pkg::RegCoefXx:  cfg_q.coef_xx    <= pwdata;
        awb_pkg::RegCoefXy:  cfg_q.coef_xy    <= pwdata;
        awb_pkg::RegCoefYx:  cfg_q.coef_yx    <= pwdata;
        awb_pkg::RegCoefYy:  cfg_q.coef_yy    <= pwdata;
        awb_pkg::RegOffsetX: cfg_q.offset_x   <= pwdata;
        awb_pkg::RegOffsetY: cfg_q.offset_y   <= pwdata;
        awb_pkg::RegSrcW:    cfg_q.src_width  <= pwdata[8:0];
        default:             cfg_q.src_height <= pwdata[8:0];
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (ridx)
      awb_pkg::RegCoefXx:  prdata = cfg_q.coef_xx;
      awb_pkg::RegCoefXy:  prdata = cfg_q.coef_xy;
      awb_pkg::RegCoefYx:  prdata = cfg_q.coef_yx;
      awb_pkg::RegCoefYy:  prdata = cfg_q.coef_yy;
      awb_pkg::RegOffsetX: prdata = cfg_q.offset_x;
      awb_pkg::RegOffsetY: prdata = cfg_q.offset_y;
      awb_pkg::RegSrcW:    prdata = {23'd0, cfg_q.src_width};
      default:             prdata = {23'd0, cfg_q.src_height};
    endcase
  end

  awb_front #(.SRC_MAX_W(SRC_MAX_W), .SRC_MAX_H(SRC_MAX_H), .DEPTH(2)) u_front (
    .clk_i, .rst_ni, .in_if,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  awb_back #(.SRC_MAX_W(SRC_MAX_W), .SRC_MAX_H(SRC_MAX_H), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop), .out_if
  );
endmodule
